FILE: rtl/core/mhjs_pkg.sv
// Shared sizes, the heap entry type and the entry ordering for the min-heap job scheduler.
// No dependencies; imported by the scheduler core, the checker and the bench.
package mhjs_pkg;

   localparam int MAX_WORKERS = 256;
   localparam int HEAP_IDX_W  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int WORKER_W    = HEAP_IDX_W;
   localparam int CNT_W       = $clog2(MAX_WORKERS + 1);
   localparam int NW_W        = 9;
   localparam int CLAMP_W     = (CNT_W > NW_W) ? CNT_W : NW_W;
   localparam int TIME_W      = 48;
   localparam int DUR_W       = 32;
   localparam int ID_W        = 8;
   localparam int NW_RESET    = 4;

   typedef struct packed {
      logic [TIME_W-1:0]   free_time;
      logic [WORKER_W-1:0] worker;
   } entry_type;

   // a sits above b: earlier free time, then lower worker index
   function automatic logic entry_ahead(entry_type a, entry_type b);
      return {a.free_time, a.worker} < {b.free_time, b.worker};
   endfunction

endpackage

FILE: rtl/core/min_heap_job_scheduler_core.sv
// Min-heap job scheduler core: heap memory, sift-down sequencer with one shared comparator.
// Depends on mhjs_pkg.
//
// Each request carries one job duration and yields one response with the worker that takes
// the job and its start time. The top of the heap is mirrored in registers, so the response
// is loaded in the cycle the request is accepted; the request port then stays stalled while
// the updated top entry is sifted down. Each heap level passes through the read, pick and test
// states (read both children, pick the better child, test it against the moving entry and
// write one entry) over a single 56-bit comparator and one heap memory with two read ports
// and one write port. Writing the worker count restarts the schedule at once: every worker
// is free at time 0, with no clearing pass.
module min_heap_job_scheduler_core
   import mhjs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [DUR_W-1:0]    req_job_duration,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ID_W-1:0]     rsp_worker_id,
   output logic [TIME_W-1:0]   rsp_start_time,
   input  logic                csr_wr_en,
   input  logic [NW_W-1:0]     csr_wr_data
);

   localparam int PW = HEAP_IDX_W + 2;

   typedef enum logic [1:0] {S_IDLE, S_READ, S_PICK, S_TEST} state_type;

   state_type               state_ff;
   logic [NW_W-1:0]         num_workers_ff;
   logic [MAX_WORKERS-1:0]  valid_ff;
   entry_type               top_ff;
   entry_type               mov_ff;
   entry_type               child_ff;
   logic [HEAP_IDX_W-1:0]   pos_ff;
   logic [HEAP_IDX_W-1:0]   child_pos_ff;
   logic                    rsp_valid_ff;
   logic [ID_W-1:0]         rsp_worker_ff;
   logic [TIME_W-1:0]       rsp_time_ff;

   entry_type               mem [MAX_WORKERS];
   entry_type               rd_l_ff;
   entry_type               rd_r_ff;
   logic                    rd_l_vld_ff;
   logic                    rd_r_vld_ff;
   logic [HEAP_IDX_W-1:0]   rd_l_idx_ff;
   logic [HEAP_IDX_W-1:0]   rd_r_idx_ff;
   logic                    r_ok_ff;

   logic [CLAMP_W-1:0]      nw_ext;
   logic [CNT_W-1:0]        active_in;
   logic [PW-1:0]           l_idx;
   logic [PW-1:0]           r_idx;
   logic [PW-1:0]           n_ext;
   logic                    l_ok;
   logic                    r_ok;
   logic [HEAP_IDX_W-1:0]   rd_l_addr;
   logic [HEAP_IDX_W-1:0]   rd_r_addr;
   entry_type               l_ent;
   entry_type               r_ent;
   entry_type               cmp_a;
   entry_type               cmp_b;
   logic                    cmp_lt;
   logic                    req_take;
   logic [TIME_W:0]         sum_in;
   logic [TIME_W-1:0]       fin_in;
   logic                    mem_we;
   entry_type               mem_wdata;

   // clamp the worker count to 1..MAX_WORKERS
   always_comb begin
      nw_ext = CLAMP_W'(num_workers_ff);
      if (nw_ext == '0) begin
         active_in = CNT_W'(1);
      end else if (nw_ext > CLAMP_W'(MAX_WORKERS)) begin
         active_in = CNT_W'(MAX_WORKERS);
      end else begin
         active_in = nw_ext[CNT_W-1:0];
      end
   end

   assign n_ext     = PW'(active_in);
   assign l_idx     = {1'b0, pos_ff, 1'b1};
   assign r_idx     = l_idx + PW'(1);
   assign l_ok      = l_idx < n_ext;
   assign r_ok      = r_idx < n_ext;
   assign rd_l_addr = l_idx[HEAP_IDX_W-1:0];
   assign rd_r_addr = r_idx[HEAP_IDX_W-1:0];

   // entries never written since restart read as (time 0, own index)
   always_comb begin
      l_ent = rd_l_ff;
      r_ent = rd_r_ff;
      if (!rd_l_vld_ff) begin
         l_ent.free_time = '0;
         l_ent.worker    = WORKER_W'(rd_l_idx_ff);
      end
      if (!rd_r_vld_ff) begin
         r_ent.free_time = '0;
         r_ent.worker    = WORKER_W'(rd_r_idx_ff);
      end
   end

   // shared comparator: right child vs left child, then best child vs moving entry
   always_comb begin
      cmp_a = child_ff;
      cmp_b = mov_ff;
      if (state_ff == S_PICK) begin
         cmp_a = r_ent;
         cmp_b = l_ent;
      end
   end
   assign cmp_lt = entry_ahead(cmp_a, cmp_b);

   assign req_take  = (state_ff == S_IDLE) && req_valid && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = !((state_ff == S_IDLE) && (!rsp_valid_ff || !rsp_stall));

   assign sum_in = {1'b0, top_ff.free_time} + (TIME_W + 1)'(req_job_duration);
   assign fin_in = sum_in[TIME_W] ? {TIME_W{1'b1}} : sum_in[TIME_W-1:0];

   assign mem_we    = ((state_ff == S_READ) && !l_ok) || (state_ff == S_TEST);
   assign mem_wdata = ((state_ff == S_TEST) && cmp_lt) ? child_ff : mov_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[pos_ff] <= mem_wdata;
      end
      rd_l_ff <= mem[rd_l_addr];
      rd_r_ff <= mem[rd_r_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         num_workers_ff <= NW_W'(NW_RESET);
         valid_ff       <= '0;
         top_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            num_workers_ff <= csr_wr_data;
            valid_ff       <= '0;
            top_ff         <= '0;
         end else if (mem_we) begin
            valid_ff[pos_ff] <= 1'b1;
            if (pos_ff == '0) begin
               top_ff <= mem_wdata;
            end
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  rsp_worker_ff      <= ID_W'(top_ff.worker);
                  rsp_time_ff        <= top_ff.free_time;
                  mov_ff.free_time   <= fin_in;
                  mov_ff.worker      <= top_ff.worker;
                  pos_ff             <= '0;
                  state_ff           <= S_READ;
               end
            end
            S_READ: begin
               rd_l_vld_ff <= valid_ff[rd_l_addr];
               rd_r_vld_ff <= valid_ff[rd_r_addr];
               rd_l_idx_ff <= rd_l_addr;
               rd_r_idx_ff <= rd_r_addr;
               r_ok_ff     <= r_ok;
               // no child in range: the moving entry lands here
               state_ff    <= l_ok ? S_PICK : S_IDLE;
            end
            S_PICK: begin
               if (r_ok_ff && cmp_lt) begin
                  child_ff     <= r_ent;
                  child_pos_ff <= rd_r_idx_ff;
               end else begin
                  child_ff     <= l_ent;
                  child_pos_ff <= rd_l_idx_ff;
               end
               state_ff <= S_TEST;
            end
            S_TEST: begin
               // child moves up into the hole, or the moving entry settles
               if (cmp_lt) begin
                  pos_ff   <= child_pos_ff;
                  state_ff <= S_READ;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_worker_id  = rsp_worker_ff;
   assign rsp_start_time = rsp_time_ff;

   a_take_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid)
      else $error("accepted request produced no response");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("request port open during sift-down");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> (PW'(pos_ff) < n_ext))
      else $error("sift position beyond worker count");

   a_rsp_from_top: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (rsp_start_time == $past(top_ff.free_time)))
      else $error("response start time differs from heap top");

endmodule

FILE: sim/schedule_checker.sv
// Scoreboard for min_heap_job_scheduler_core: keeps its own copy of the worker heap,
// predicts worker and start time for each accepted request and checks each response.
// Depends on mhjs_pkg.
module schedule_checker
   import mhjs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [DUR_W-1:0]  req_job_duration,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [ID_W-1:0]   rsp_worker_id,
   input  logic [TIME_W-1:0] rsp_start_time,
   input  logic              csr_wr_en,
   input  logic [NW_W-1:0]   csr_wr_data,
   output int                error_count,
   output int                open_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [ID_W-1:0]   worker_id;
      logic [TIME_W-1:0] start_time;
   } assignment_type;

   logic [TIME_W-1:0]   free_at [MAX_WORKERS];
   logic [WORKER_W-1:0] owner   [MAX_WORKERS];
   logic [NW_W-1:0]     worker_setting;
   assignment_type      assignment_q [$];
   int                  errors = 0;

   function automatic void clear_schedule();
      for (int i = 0; i < MAX_WORKERS; i++) begin
         free_at[i] = '0;
         owner[i]   = WORKER_W'(i);
      end
   endfunction

   function automatic int workers_in_use();
      if (worker_setting == 0) return 1;
      if (worker_setting > MAX_WORKERS) return MAX_WORKERS;
      return int'(worker_setting);
   endfunction

   function automatic bit sits_above(int a, int b);
      if (free_at[a] != free_at[b]) return free_at[a] < free_at[b];
      return owner[a] < owner[b];
   endfunction

   // hand the job to the top worker, push its free time out, sift the entry down
   function automatic assignment_type assign_job(logic [DUR_W-1:0] duration);
      assignment_type      due;
      logic [TIME_W:0]     finish;
      logic [TIME_W-1:0]   t;
      logic [WORKER_W-1:0] w;
      int                  n;
      int                  pos;
      int                  best;
      int                  kid;
      bit                  settled;
      n = workers_in_use();
      due.worker_id  = ID_W'(owner[0]);
      due.start_time = free_at[0];
      finish = {1'b0, free_at[0]} + {{(TIME_W + 1 - DUR_W){1'b0}}, duration};
      free_at[0] = finish[TIME_W] ? '1 : finish[TIME_W-1:0];
      pos = 0;
      settled = 1'b0;
      while (!settled) begin
         best = pos;
         for (kid = 2 * pos + 1; kid <= 2 * pos + 2; kid++)
            if (kid < n && sits_above(kid, best)) best = kid;
         if (best == pos) begin
            settled = 1'b1;
         end else begin
            t = free_at[pos];
            free_at[pos] = free_at[best];
            free_at[best] = t;
            w = owner[pos];
            owner[pos] = owner[best];
            owner[best] = w;
            pos = best;
         end
      end
      return due;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      errors++;
   endtask

   always @(posedge clock) begin
      assignment_type due;
      if (reset) begin
         worker_setting = NW_W'(NW_RESET);
         clear_schedule();
         assignment_q.delete();
      end else begin
         if (csr_wr_en) begin
            worker_setting = csr_wr_data;
            clear_schedule();
         end
         if (req_valid && !req_stall)
            assignment_q.push_back(assign_job(req_job_duration));
         if (rsp_valid && !rsp_stall) begin
            if (assignment_q.size() == 0) begin
               report_mismatch($sformatf("response with no request pending: worker %0d start %0d",
                                         rsp_worker_id, rsp_start_time));
            end else begin
               due = assignment_q.pop_front();
               if (rsp_worker_id !== due.worker_id)
                  report_mismatch($sformatf("worker_id got %0d, want %0d",
                                            rsp_worker_id, due.worker_id));
               if (rsp_start_time !== due.start_time)
                  report_mismatch($sformatf("start_time got %0d, want %0d",
                                            rsp_start_time, due.start_time));
            end
         end
      end
      error_count <= errors;
      open_count  <= assignment_q.size();
   end

endmodule

FILE: sim/testbench.sv
// Top of the min_heap_job_scheduler_core bench: clock, reset, request and response traffic,
// worker count writes and the verdict. Depends on mhjs_pkg, the core and schedule_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mhjs_pkg::*;

   localparam int SIFT_SETTLE     = 32;
   localparam int IDLE_LIMIT      = 5000;
   localparam int HOLD_CYCLES     = 300;
   localparam int TAIL_JOBS       = 20;

   logic              clock;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_stall;
   logic [DUR_W-1:0]  req_job_duration = '0;
   logic              rsp_valid;
   logic              rsp_stall        = 1'b0;
   logic [ID_W-1:0]   rsp_worker_id;
   logic [TIME_W-1:0] rsp_start_time;
   logic              csr_wr_en        = 1'b0;
   logic [NW_W-1:0]   csr_wr_data      = '0;

   int fails;
   int open_jobs;
   bit sender_gaps = 1'b1;
   bit quiet_tail  = 1'b0;
   bit hold_armed  = 1'b0;
   bit hold_done   = 1'b0;

   min_heap_job_scheduler_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_job_duration (req_job_duration),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_worker_id    (rsp_worker_id),
      .rsp_start_time   (rsp_start_time),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   schedule_checker assign_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_job_duration (req_job_duration),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_worker_id    (rsp_worker_id),
      .rsp_start_time   (rsp_start_time),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .error_count      (fails),
      .open_count       (open_jobs)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic send_job(input logic [DUR_W-1:0] duration);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_job_duration <= duration;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_jobs != 0) @(posedge clock);
   endtask

   // the core may still be sifting after its last response, so let it settle first
   task automatic write_workers(input logic [NW_W-1:0] setting);
      drain_results();
      repeat (SIFT_SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= setting;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // response side: random stall bursts, one long hold-off, none at the tail
   initial begin
      int span;
      @(posedge clock);
      forever begin
         if (hold_armed && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (quiet_tail) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            span = $urandom_range(0, 9);
            rsp_stall <= (span < 3);
            repeat ((span < 9) ? $urandom_range(1, 7) : $urandom_range(20, 60))
               @(posedge clock);
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || csr_wr_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("min_heap_job_scheduler_core verification failed");
      $finish;
   end

   initial begin
      logic [NW_W-1:0]  setting;
      logic [DUR_W-1:0] duration;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // zero-length jobs at time zero tie-break by index, then mixed lengths
      send_job(0); send_job(0); send_job(0); send_job(0); send_job(0); send_job(5);
      send_job('1); send_job(3); send_job(1); send_job(0); send_job(7); send_job(7);
      write_workers(NW_W'(1));
      send_job(0); send_job('1); send_job(2);
      // zero count runs as a single worker
      write_workers(NW_W'(0));
      send_job(1); send_job(0); send_job(4);
      // counts above the heap size clamp to it
      write_workers('1);
      send_job(0); send_job(0); send_job(0); send_job(1);
      write_workers(NW_W'(MAX_WORKERS));
      send_job(0); send_job(0); send_job(0); send_job('1);

      for (int phase = 0; phase < 14; phase++) begin
         case ($urandom_range(0, 9))
            0:       setting = $urandom_range(0, 1) ? '0 : NW_W'($urandom_range(257, 511));
            1, 2:    setting = NW_W'($urandom_range(17, MAX_WORKERS));
            default: setting = NW_W'($urandom_range(1, 16));
         endcase
         if (phase == 0) setting = NW_W'(MAX_WORKERS);
         write_workers(setting);
         // keep offering during the hold-off so the core backs up
         sender_gaps = (phase != 3);
         if (phase == 3) hold_armed = 1'b1;
         for (int k = 0; k < 100; k++) begin
            if (phase == 6 && k == 50) drain_results();
            case ($urandom_range(0, 9))
               0:       duration = '0;
               1:       duration = '1;
               2, 3, 4: duration = DUR_W'($urandom_range(0, 15));
               5, 6:    duration = DUR_W'($urandom_range(0, 1000));
               default: duration = $urandom;
            endcase
            send_job(duration);
         end
      end

      // one worker, longest jobs back to back with no idling at the tail
      quiet_tail  = 1'b1;
      sender_gaps = 1'b0;
      write_workers(NW_W'(1));
      repeat (TAIL_JOBS) send_job('1);
      send_job(0);
      send_job(5);

      drain_results();
      repeat (SIFT_SETTLE) @(posedge clock);
      if (fails == 0 && open_jobs == 0)
         $display("min_heap_job_scheduler_core verification clean");
      else
         $display("min_heap_job_scheduler_core verification failed");
      $finish;
   end

endmodule
